/* sv/ipf_pkg.sv */
`default_nettype none
package ipf_pkg;

    localparam int ADDR_W = 128;
    localparam int HALF_W = 64;
    localparam int V4_W   = 32;
    localparam int MASK_W = 8;

    localparam logic [MASK_W-1:0] V4_MAX_LEN = 8'd32;
    localparam logic [MASK_W-1:0] V6_MAX_LEN = 8'd128;

    typedef enum logic [2:0] {
        OP_EQUAL    = 3'd0,
        OP_NEQUAL   = 3'd1,
        OP_LOWER    = 3'd2,
        OP_HIGHER   = 3'd3,
        OP_WITHIN   = 3'd4,
        OP_CONTAINS = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        REL_NOMATCH  = 2'd0,
        REL_EQUALS   = 2'd1,
        REL_INCLUDED = 2'd2,
        REL_INCLUDES = 2'd3
    } t_rel;

    // after alignment: both addresses left-aligned to 128 bits
    typedef struct packed {
        t_op               op;
        logic              err;
        logic              same;
        logic [ADDR_W-1:0] t_addr;
        logic [ADDR_W-1:0] r_addr;
        logic [MASK_W-1:0] min_len;
        logic              t_lt;
        logic              t_gt;
    } t_s1;

    // after compare: addresses are dropped; only the operator and flags remain
    typedef struct packed {
        t_op  op;
        logic err;
        logic same;
        logic t_lt;
        logic t_gt;
        logic top_eq;
        logic hi_eq;
        logic hi_lt;
        logic lo_eq;
        logic lo_lt;
    } t_s2;

endpackage
`default_nettype wire

/* sv/ipf_if.sv */
`default_nettype none
interface ipf_req_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   req_type;
    logic                         test_is_v6;
    logic [ipf_pkg::HALF_W-1:0]   test_addr_hi;
    logic [ipf_pkg::HALF_W-1:0]   test_addr_lo;
    logic [ipf_pkg::MASK_W-1:0]   test_mask;
    logic                         ref_is_v6;
    logic [ipf_pkg::HALF_W-1:0]   ref_addr_hi;
    logic [ipf_pkg::HALF_W-1:0]   ref_addr_lo;
    logic [ipf_pkg::MASK_W-1:0]   ref_mask;

    modport source (
        output valid, req_type, test_is_v6, test_addr_hi, test_addr_lo, test_mask,
               ref_is_v6, ref_addr_hi, ref_addr_lo, ref_mask,
        input  ready
    );
    modport sink (
        input  valid, req_type, test_is_v6, test_addr_hi, test_addr_lo, test_mask,
               ref_is_v6, ref_addr_hi, ref_addr_lo, ref_mask,
        output ready
    );
endinterface

interface ipf_res_if;
    logic valid;
    logic ready;
    logic verdict;
    logic error;

    modport source (output valid, verdict, error, input ready);
    modport sink (input valid, verdict, error, output ready);
endinterface
`default_nettype wire

/* sv/ipf_align.sv */
`default_nettype none
module ipf_align (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    ipf_req_if.sink           i_req,
    output ipf_pkg::t_s1      o_data,
    output logic              o_valid,
    input  wire logic         i_ready
);
    logic         r_valid;
    ipf_pkg::t_s1 r_data;
    ipf_pkg::t_s1 n_data;
    logic         accept;

    assign i_req.ready = !r_valid || i_ready;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_data.op   = ipf_pkg::t_op'(i_req.req_type);
        n_data.same = (i_req.test_is_v6 == i_req.ref_is_v6);
        n_data.err  = (i_req.req_type > ipf_pkg::OP_CONTAINS)
                   || (i_req.test_mask > (i_req.test_is_v6 ? ipf_pkg::V6_MAX_LEN
                                                            : ipf_pkg::V4_MAX_LEN))
                   || (i_req.ref_mask > (i_req.ref_is_v6 ? ipf_pkg::V6_MAX_LEN
                                                          : ipf_pkg::V4_MAX_LEN));
        // ipv4 goes to the top 32 bits so both families share one compare
        if (i_req.test_is_v6) begin
            n_data.t_addr = {i_req.test_addr_hi, i_req.test_addr_lo};
        end else begin
            n_data.t_addr = {i_req.test_addr_lo[ipf_pkg::V4_W-1:0],
                             {(ipf_pkg::ADDR_W-ipf_pkg::V4_W){1'b0}}};
        end
        if (i_req.ref_is_v6) begin
            n_data.r_addr = {i_req.ref_addr_hi, i_req.ref_addr_lo};
        end else begin
            n_data.r_addr = {i_req.ref_addr_lo[ipf_pkg::V4_W-1:0],
                             {(ipf_pkg::ADDR_W-ipf_pkg::V4_W){1'b0}}};
        end
        n_data.t_lt    = (i_req.test_mask < i_req.ref_mask);
        n_data.t_gt    = (i_req.test_mask > i_req.ref_mask);
        n_data.min_len = n_data.t_lt ? i_req.test_mask : i_req.ref_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

/* sv/ipf_compare.sv */
`default_nettype none
module ipf_compare (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ipf_pkg::t_s1  i_data,
    input  wire logic          i_valid,
    output logic               o_ready,
    output ipf_pkg::t_s2       o_data,
    output logic               o_valid,
    input  wire logic          i_ready
);
    logic                       r_valid;
    ipf_pkg::t_s2               r_data;
    ipf_pkg::t_s2               n_data;
    logic [ipf_pkg::ADDR_W-1:0] pmask;
    logic [ipf_pkg::ADDR_W-1:0] diff;
    logic [ipf_pkg::HALF_W-1:0] t_hi, t_lo, r_hi, r_lo;

    assign o_ready = !r_valid || i_ready;

    assign t_hi = i_data.t_addr[ipf_pkg::ADDR_W-1:ipf_pkg::HALF_W];
    assign t_lo = i_data.t_addr[ipf_pkg::HALF_W-1:0];
    assign r_hi = i_data.r_addr[ipf_pkg::ADDR_W-1:ipf_pkg::HALF_W];
    assign r_lo = i_data.r_addr[ipf_pkg::HALF_W-1:0];

    // the leading min_len bits are set; zero length compares nothing
    always_comb begin
        for (int i = 0; i < ipf_pkg::ADDR_W; i++) begin
            pmask[ipf_pkg::ADDR_W-1-i] = (ipf_pkg::MASK_W'(i) < i_data.min_len);
        end
    end

    assign diff = i_data.t_addr ^ i_data.r_addr;

    always_comb begin
        n_data.op     = i_data.op;
        n_data.err    = i_data.err;
        n_data.same   = i_data.same;
        n_data.t_lt   = i_data.t_lt;
        n_data.t_gt   = i_data.t_gt;
        n_data.top_eq = ((diff & pmask) == '0);
        n_data.hi_eq  = (t_hi == r_hi);
        n_data.hi_lt  = (t_hi < r_hi);
        n_data.lo_eq  = (t_lo == r_lo);
        n_data.lo_lt  = (t_lo < r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

/* sv/ipf_decide.sv */
`default_nettype none
module ipf_decide (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ipf_pkg::t_s2  i_data,
    input  wire logic          i_valid,
    output logic               o_ready,
    ipf_res_if.source          o_res
);
    logic          r_valid;
    logic          r_verdict;
    logic          r_error;
    logic          n_verdict;
    logic          n_error;
    logic          lower;
    ipf_pkg::t_rel rel;

    assign o_ready = !r_valid || o_res.ready;

    always_comb begin
        if (!i_data.same || !i_data.top_eq) begin
            rel = ipf_pkg::REL_NOMATCH;
        end else if (i_data.t_gt) begin
            rel = ipf_pkg::REL_INCLUDED;
        end else if (i_data.t_lt) begin
            rel = ipf_pkg::REL_INCLUDES;
        end else begin
            rel = ipf_pkg::REL_EQUALS;
        end
    end

    // equal addresses: the shorter mask sorts first
    always_comb begin
        priority if (i_data.hi_eq && i_data.lo_eq) begin
            lower = i_data.t_lt;
        end else if (!i_data.hi_eq) begin
            lower = i_data.hi_lt;
        end else begin
            lower = i_data.lo_lt;
        end
    end

    always_comb begin
        n_verdict = 1'b0;
        n_error   = i_data.err;
        if (!i_data.err) begin
            unique case (i_data.op)
                ipf_pkg::OP_EQUAL:    n_verdict = (rel == ipf_pkg::REL_EQUALS);
                ipf_pkg::OP_NEQUAL:   n_verdict = (rel != ipf_pkg::REL_EQUALS);
                ipf_pkg::OP_LOWER: begin
                    n_error   = !i_data.same;
                    n_verdict = i_data.same && lower;
                end
                ipf_pkg::OP_HIGHER:   n_verdict = i_data.same && !lower
                                                  && (rel != ipf_pkg::REL_EQUALS);
                ipf_pkg::OP_WITHIN:   n_verdict = (rel == ipf_pkg::REL_INCLUDED)
                                                  || (rel == ipf_pkg::REL_EQUALS);
                ipf_pkg::OP_CONTAINS: n_verdict = (rel == ipf_pkg::REL_INCLUDES)
                                                  || (rel == ipf_pkg::REL_EQUALS);
                default:              n_error   = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_verdict <= n_verdict;
            r_error   <= n_error;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.verdict = r_verdict;
    assign o_res.error   = r_error;

    a_err_no_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_error |-> !r_verdict)
        else $error("verdict set together with error");

    a_early_err_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.err |=> r_valid && r_error)
        else $error("error flagged upstream lost in final stage");

endmodule
`default_nettype wire

/* sv/ip_prefix_filter.sv */
// ip_prefix_filter: ipv4/ipv6 prefix relation test
// i_req carries an operator plus a test and a reference prefix (family, 128-bit
// address as hi/lo words, mask length); o_res returns one word per request
// with a verdict bit and an error bit. verdict is always 0 when error is 1.
// both channels use valid/ready; a word moves when both are high.
// pipeline: align (family left-align, mask checks, shorter mask) ->
// compare (masked prefix compare, 64-bit address compares) ->
// decide (relation, operator, output register).
// each request is registered in align, compare and decide in turn; o_res.valid
// rises once it sits in decide. throughput: one request per cycle while
// o_res.ready is high; every stage holds a valid bit and takes a new word
// when it is empty or its word moves on at the same edge.
// when the receiver holds o_res.ready low the words back up stage by stage;
// i_req.ready drops only once all three stages are full, nothing is dropped.
// reset (i_rst_n low, synchronous) clears all valid bits; the pipeline is
// empty and i_req.ready is high in the first cycle after reset.
`default_nettype none
module ip_prefix_filter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ipf_req_if.sink   i_req,
    ipf_res_if.source o_res
);
    ipf_pkg::t_s1 s1_data;
    logic         s1_valid;
    logic         s1_ready;
    ipf_pkg::t_s2 s2_data;
    logic         s2_valid;
    logic         s2_ready;

    ipf_align u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_data  (s1_data),
        .o_valid (s1_valid),
        .i_ready (s1_ready)
    );

    ipf_compare u_compare (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (s1_data),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .o_data  (s2_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready)
    );

    ipf_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (s2_data),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .o_res   (o_res)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid && !s1_valid && !s2_valid)
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
